// ===== hw/rtl/ms_pkg.sv =====
// ----------------------------------------------------------------------------
// ms_pkg
// Shared types and constants of the merge sorter: payload structs, the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ms_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic               last_res;
    logic               overflow;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // store one input item
    logic init;    // set up the first merge pass
    logic mrd;     // read both run heads
    logic mwr;     // write the smaller head, advance
    logic ord;     // read the next sorted value
    logic owr;     // present it, advance
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pass_end;  // current element is the last of the set
    logic sort_end;  // the pass just ending is the final one
    logic single;    // set holds at most one element
  } stat_t;

endpackage

// ===== hw/rtl/ms_ctrl.sv =====
// ----------------------------------------------------------------------------
// ms_ctrl
// Sequencer of the merge sorter: loading, merge passes and read-out.
// ----------------------------------------------------------------------------
module ms_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          last_i,
  input  ms_pkg::stat_t stat_i,
  output logic          busy,
  output logic          res_valid_o,
  output ms_pkg::cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_INIT   = 6'b000010,
    ST_MRD    = 6'b000100,
    ST_MWR    = 6'b001000,
    ST_ORD    = 6'b010000,
    ST_OWR    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (last_i) begin
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = stat_i.single ? ST_ORD : ST_MRD;
      end
      ST_MRD: begin
        cmd_o.mrd = 1'b1;
        state_d   = ST_MWR;
      end
      ST_MWR: begin
        cmd_o.mwr = 1'b1;
        if (stat_i.pass_end && stat_i.sort_end) begin
          state_d = ST_ORD;
        end else begin
          state_d = ST_MRD;
        end
      end
      ST_ORD: begin
        cmd_o.ord = 1'b1;
        state_d   = ST_OWR;
      end
      ST_OWR: begin
        cmd_o.owr = 1'b1;
        state_d   = stat_i.pass_end ? ST_IDLE : ST_ORD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_OWR);

endmodule

// ===== hw/rtl/ms_datapath.sv =====
// ----------------------------------------------------------------------------
// ms_datapath
// Two value memories used in ping-pong fashion, run pointers, the signed
// compare and the element counters of the merge sorter.
// ----------------------------------------------------------------------------
module ms_datapath #(
  parameter int unsigned DEPTH = ms_pkg::DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ms_pkg::cmd_t      cmd_i,
  input  ms_pkg::in_item_t  in_i,
  output ms_pkg::stat_t     stat_o,
  output ms_pkg::out_item_t res_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = CW + 1;
  localparam int unsigned SW = CW + 2;

  logic signed [31:0] mem_a [DEPTH];
  logic signed [31:0] mem_b [DEPTH];

  logic signed [31:0] a_rd0_q, a_rd1_q, b_rd0_q, b_rd1_q;

  logic [CW-1:0] count_q, count_d;
  logic          dropped_q, dropped_d;
  logic [WW-1:0] width_q, width_d;
  logic [CW-1:0] left_q, left_d, right_q, right_d;
  logic [CW-1:0] mid_q, mid_d, hi_q, hi_d, k_q, k_d;
  logic          src_q, src_d;  // 0: read mem_a, write mem_b

  logic               full;
  logic signed [31:0] left_val, right_val, merged;
  logic               take_left;
  logic [SW-1:0]      n_ext, hi_ext, w_ext, w2_ext;
  logic [SW-1:0]      sum_mid, sum_hi;
  logic [AW-1:0]      rd0_addr, rd1_addr;
  logic               rd_en;

  function automatic logic [SW-1:0] min_sw(input logic [SW-1:0] a, input logic [SW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  assign full   = (count_q == CW'(DEPTH));
  assign n_ext  = SW'(count_q);
  assign hi_ext = SW'(hi_q);
  assign w_ext  = SW'(width_q);
  assign w2_ext = w_ext << 1;

  // Bounds of the next run pair within the current pass.
  assign sum_mid = min_sw(hi_ext + w_ext, n_ext);
  assign sum_hi  = min_sw(hi_ext + w2_ext, n_ext);

  assign left_val  = src_q ? b_rd0_q : a_rd0_q;
  assign right_val = src_q ? b_rd1_q : a_rd1_q;
  assign take_left = (left_q < mid_q) && ((right_q >= hi_q) || !(right_val < left_val));
  assign merged    = take_left ? left_val : right_val;

  assign stat_o.pass_end = ((k_q + CW'(1)) == count_q);
  assign stat_o.sort_end = (w2_ext >= n_ext);
  assign stat_o.single   = (count_q <= CW'(1));

  assign rd0_addr = cmd_i.ord ? k_q[AW-1:0] : left_q[AW-1:0];
  assign rd1_addr = right_q[AW-1:0];
  assign rd_en    = cmd_i.mrd || cmd_i.ord;

  // Memory A: loaded from the input, and the target of the second, fourth and later even passes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      mem_a[count_q[AW-1:0]] <= in_i.value;
    end else if (cmd_i.mwr && src_q) begin
      mem_a[k_q[AW-1:0]] <= merged;
    end
    if (rd_en) begin
      a_rd0_q <= mem_a[rd0_addr];
      a_rd1_q <= mem_a[rd1_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mwr && !src_q) begin
      mem_b[k_q[AW-1:0]] <= merged;
    end
    if (rd_en) begin
      b_rd0_q <= mem_b[rd0_addr];
      b_rd1_q <= mem_b[rd1_addr];
    end
  end

  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    width_d   = width_q;
    left_d    = left_q;
    right_d   = right_q;
    mid_d     = mid_q;
    hi_d      = hi_q;
    k_d       = k_q;
    src_d     = src_q;
    if (cmd_i.load) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
      end
    end
    if (cmd_i.init) begin
      width_d = WW'(1);
      k_d     = '0;
      left_d  = '0;
      src_d   = 1'b0;
      mid_d   = CW'(min_sw(SW'(1), n_ext));
      right_d = CW'(min_sw(SW'(1), n_ext));
      hi_d    = CW'(min_sw(SW'(2), n_ext));
    end
    if (cmd_i.mwr) begin
      if (stat_o.pass_end) begin
        // Next pass: runs twice as wide, buffers swap roles.
        width_d = width_q << 1;
        k_d     = '0;
        left_d  = '0;
        src_d   = !src_q;
        mid_d   = CW'(min_sw(w2_ext, n_ext));
        right_d = CW'(min_sw(w2_ext, n_ext));
        hi_d    = CW'(min_sw(w2_ext << 1, n_ext));
      end else if ((k_q + CW'(1)) == hi_q) begin
        k_d     = k_q + CW'(1);
        left_d  = hi_q;
        mid_d   = CW'(sum_mid);
        right_d = CW'(sum_mid);
        hi_d    = CW'(sum_hi);
      end else begin
        k_d = k_q + CW'(1);
        if (take_left) begin
          left_d = left_q + CW'(1);
        end else begin
          right_d = right_q + CW'(1);
        end
      end
    end
    if (cmd_i.owr) begin
      if (stat_o.pass_end) begin
        count_d   = '0;
        dropped_d = 1'b0;
        k_d       = '0;
      end else begin
        k_d = k_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      width_q   <= '0;
      left_q    <= '0;
      right_q   <= '0;
      mid_q     <= '0;
      hi_q      <= '0;
      k_q       <= '0;
      src_q     <= 1'b0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
      width_q   <= width_d;
      left_q    <= left_d;
      right_q   <= right_d;
      mid_q     <= mid_d;
      hi_q      <= hi_d;
      k_q       <= k_d;
      src_q     <= src_d;
    end
  end

  // The sorted value was read from the buffer written by the final pass, or from memory A when no pass ran.
  assign res_o.value_res = src_q ? b_rd0_q : a_rd0_q;
  assign res_o.last_res  = stat_o.pass_end;
  assign res_o.overflow  = dropped_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("element count exceeds capacity");

  a_merge_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mwr |-> (k_q < count_q))
    else $error("merge write beyond the loaded set");

  a_merge_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mwr |-> ((left_q < mid_q) || (right_q < hi_q)))
    else $error("merge write with both runs exhausted");

  a_out_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.owr |-> (k_q < count_q))
    else $error("result emitted beyond the loaded set");

endmodule

// ===== hw/rtl/merge_sorter.sv =====
// ----------------------------------------------------------------------------
// merge_sorter
// Batch sorter for signed 32-bit values: loads up to DEPTH values, sorts
// them ascending by bottom-up merge sort after the item marked last, and
// emits them in order.
//
//   Channel  Handshake                  Payload
//   input    start / busy               in_i  (value, last)
//   result   res_valid_o, one cycle     res_o (value_res, last_res, overflow)
//
// Loading accepts one transfer per cycle while busy is low.
// After the last transfer, each merged value takes a read state (MRD) and
// a write state (MWR) on the value memories.
// Each result is read in ORD and presented in OWR; results cannot be held off.
// Reset clears the controller and counters; memory contents need none.
// ----------------------------------------------------------------------------
module merge_sorter #(
  parameter int unsigned DEPTH = ms_pkg::DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ms_pkg::in_item_t  in_i,
  output logic              res_valid_o,
  output ms_pkg::out_item_t res_o
);

  ms_pkg::cmd_t  cmd;
  ms_pkg::stat_t stat;
  logic          busy_int;

  ms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .last_i      (in_i.last),
    .stat_i      (stat),
    .busy        (busy_int),
    .res_valid_o (res_valid_o),
    .cmd_o       (cmd)
  );

  ms_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .in_i   (in_i),
    .stat_o (stat),
    .res_o  (res_o)
  );

  assign busy = busy_int;

endmodule
